// ===== src/sm83_subset_instruction_executor_assert.svh =====
// assertion macros shared by the executor rtl
`ifndef SM83_SUBSET_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define SM83_SUBSET_INSTRUCTION_EXECUTOR_ASSERT_SVH

`ifndef SYNTHESIS
// property checked at every rising clock edge outside reset
`define SM83_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sm83 assertion failed");
// condition that must never hold outside reset
`define SM83_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sm83 forbidden condition");
`else
`define SM83_ASSERT(lbl, clk, rst_n, prop)
`define SM83_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== src/sm83_pkg.sv =====
package sm83_pkg;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // supported opcodes
  localparam logic [7:0] OP_LD_BC_I16  = 8'h01;
  localparam logic [7:0] OP_LD_DE_I16  = 8'h11;
  localparam logic [7:0] OP_LD_HL_I16  = 8'h21;
  localparam logic [7:0] OP_LD_SP_I16  = 8'h31;
  localparam logic [7:0] OP_ST_BC_A    = 8'h02;
  localparam logic [7:0] OP_ST_DE_A    = 8'h12;
  localparam logic [7:0] OP_LD_A_BC    = 8'h0a;
  localparam logic [7:0] OP_LD_A_DE    = 8'h1a;
  localparam logic [7:0] OP_ST_HLI_A   = 8'h22;
  localparam logic [7:0] OP_LD_A_HLI   = 8'h2a;
  localparam logic [7:0] OP_ST_HLD_A   = 8'h32;
  localparam logic [7:0] OP_LD_A_HLD   = 8'h3a;
  localparam logic [7:0] OP_LD_B_I8    = 8'h06;
  localparam logic [7:0] OP_LD_C_I8    = 8'h0e;
  localparam logic [7:0] OP_LD_D_I8    = 8'h16;
  localparam logic [7:0] OP_LD_E_I8    = 8'h1e;
  localparam logic [7:0] OP_LD_H_I8    = 8'h26;
  localparam logic [7:0] OP_LD_L_I8    = 8'h2e;
  localparam logic [7:0] OP_ST_HL_I8   = 8'h36;
  localparam logic [7:0] OP_LD_A_I8    = 8'h3e;
  localparam logic [7:0] OP_DEC_C      = 8'h0d;
  localparam logic [7:0] OP_CPL        = 8'h2f;
  localparam logic [7:0] OP_XOR_B      = 8'ha8;
  localparam logic [7:0] OP_XOR_A      = 8'haf;
  localparam logic [7:0] OP_JP_A16     = 8'hc3;
  localparam logic [7:0] OP_ADD_A_I8   = 8'hc6;
  localparam logic [7:0] OP_CALL_A16   = 8'hcd;
  localparam logic [7:0] OP_LDH_ST_A   = 8'he0;
  localparam logic [7:0] OP_LDH_LD_A   = 8'hf0;
  localparam logic [7:0] OP_LD_HL_SPR  = 8'hf8;
  localparam logic [7:0] OP_LD_SP_HL   = 8'hf9;

  // write counts
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_ONE  = 2'd1;
  localparam logic [1:0] WR_TWO  = 2'd2;

  // high page base for ldh
  localparam logic [7:0] HIGH_PAGE = 8'hff;

  typedef struct packed {
    logic [7:0]  a;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
    logic [3:0]  flags;
  } arch_state_t;

  localparam arch_state_t RESET_STATE = '{
    a:     8'h11,
    bc:    16'h0000,
    de:    16'hff56,
    hl:    16'h000d,
    sp:    16'hfffe,
    pc:    16'h0000,
    flags: 4'b1000
  };

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] imm_lo;
    logic [7:0] imm_hi;
    logic [7:0] mem_rdata;
  } insn_t;

  typedef struct packed {
    logic [1:0]  wr_count;
    logic [15:0] wr_addr;
    logic [15:0] wr_data;
    logic [4:0]  cycle_cost;
    logic        unimplemented;
  } exec_res_t;

endpackage

// ===== src/sm83_if.sv =====
// instruction channel
interface sm83_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] imm_lo;
  logic [7:0] imm_hi;
  logic [7:0] mem_rdata;

  modport source (output valid, output opcode, output imm_lo, output imm_hi,
                  output mem_rdata, input ready);
  modport sink (input valid, input opcode, input imm_lo, input imm_hi,
                input mem_rdata, output ready);
endinterface

// result channel
interface sm83_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [7:0]  acc;
  logic [15:0] pair_bc;
  logic [15:0] pair_de;
  logic [15:0] pair_hl;
  logic [15:0] stack_ptr;
  logic [3:0]  flag_bits;
  logic [1:0]  wr_count;
  logic [15:0] wr_addr;
  logic [15:0] wr_data;
  logic [4:0]  cycle_cost;
  logic        unimplemented;

  modport source (output valid, output next_pc, output acc, output pair_bc,
                  output pair_de, output pair_hl, output stack_ptr,
                  output flag_bits, output wr_count, output wr_addr,
                  output wr_data, output cycle_cost, output unimplemented,
                  input ready);
  modport sink (input valid, input next_pc, input acc, input pair_bc,
                input pair_de, input pair_hl, input stack_ptr,
                input flag_bits, input wr_count, input wr_addr,
                input wr_data, input cycle_cost, input unimplemented,
                output ready);
endinterface

// ===== src/sm83_in_stage.sv =====
module sm83_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sm83_pkg::insn_t in_insn_i,
  input  logic           adv_i,
  output logic           valid_o,
  output sm83_pkg::insn_t insn_o
);
  import sm83_pkg::*;

  logic  valid_q, valid_d;
  insn_t insn_q;

  // take a beat whenever the held one leaves or the stage is empty
  assign in_ready_o = !valid_q || adv_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      insn_q <= in_insn_i;
    end
  end

  assign valid_o = valid_q;
  assign insn_o  = insn_q;

endmodule

// ===== src/sm83_exec.sv =====
module sm83_exec (
  input  sm83_pkg::arch_state_t cur_i,
  input  sm83_pkg::insn_t       insn_i,
  output sm83_pkg::arch_state_t nxt_o,
  output sm83_pkg::exec_res_t   res_o
);
  import sm83_pkg::*;

  arch_state_t nxt;
  exec_res_t   res;
  logic [15:0] imm16;
  logic [1:0]  len;
  logic        jump;
  logic [7:0]  lo;
  logic [7:0]  dec_c;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [15:0] sp_sum;
  logic [8:0]  sp_lo_sum;
  logic [4:0]  sp_half;

  assign lo        = insn_i.imm_lo;
  assign imm16     = {insn_i.imm_hi, insn_i.imm_lo};
  assign dec_c     = cur_i.bc[7:0] - 8'd1;
  assign add_sum   = {1'b0, cur_i.a} + {1'b0, lo};
  assign add_half  = {1'b0, cur_i.a[3:0]} + {1'b0, lo[3:0]};
  assign sp_sum    = cur_i.sp + {{8{lo[7]}}, lo};
  assign sp_lo_sum = {1'b0, cur_i.sp[7:0]} + {1'b0, lo};
  assign sp_half   = {1'b0, cur_i.sp[3:0]} + {1'b0, lo[3:0]};

  // opcode dispatch
  always_comb begin
    nxt  = cur_i;
    len  = 2'd1;
    jump = 1'b0;
    res  = '{wr_count: WR_NONE, wr_addr: 16'h0000, wr_data: 16'h0000,
             cycle_cost: 5'd0, unimplemented: 1'b0};
    case (insn_i.opcode)
      OP_LD_BC_I16: begin
        nxt.bc = imm16; len = 2'd3; res.cycle_cost = 5'd12;
      end
      OP_LD_DE_I16: begin
        nxt.de = imm16; len = 2'd3; res.cycle_cost = 5'd12;
      end
      OP_LD_HL_I16: begin
        nxt.hl = imm16; len = 2'd3; res.cycle_cost = 5'd12;
      end
      OP_LD_SP_I16: begin
        nxt.sp = imm16; len = 2'd3; res.cycle_cost = 5'd12;
      end
      OP_ST_BC_A: begin
        res.wr_count = WR_ONE; res.wr_addr = cur_i.bc;
        res.wr_data = {8'h00, cur_i.a}; res.cycle_cost = 5'd8;
      end
      OP_ST_DE_A: begin
        res.wr_count = WR_ONE; res.wr_addr = cur_i.de;
        res.wr_data = {8'h00, cur_i.a}; res.cycle_cost = 5'd8;
      end
      OP_LD_A_BC, OP_LD_A_DE: begin
        nxt.a = insn_i.mem_rdata; res.cycle_cost = 5'd8;
      end
      OP_ST_HLI_A: begin
        res.wr_count = WR_ONE; res.wr_addr = cur_i.hl;
        res.wr_data = {8'h00, cur_i.a};
        nxt.hl = cur_i.hl + 16'd1; res.cycle_cost = 5'd8;
      end
      OP_LD_A_HLI: begin
        nxt.a = insn_i.mem_rdata; nxt.hl = cur_i.hl + 16'd1;
        res.cycle_cost = 5'd8;
      end
      OP_ST_HLD_A: begin
        res.wr_count = WR_ONE; res.wr_addr = cur_i.hl;
        res.wr_data = {8'h00, cur_i.a};
        nxt.hl = cur_i.hl - 16'd1; res.cycle_cost = 5'd8;
      end
      OP_LD_A_HLD: begin
        nxt.a = insn_i.mem_rdata; nxt.hl = cur_i.hl - 16'd1;
        res.cycle_cost = 5'd8;
      end
      OP_LD_B_I8: begin
        nxt.bc[15:8] = lo; len = 2'd2; res.cycle_cost = 5'd8;
      end
      OP_LD_C_I8: begin
        nxt.bc[7:0] = lo; len = 2'd2; res.cycle_cost = 5'd8;
      end
      OP_LD_D_I8: begin
        nxt.de[15:8] = lo; len = 2'd2; res.cycle_cost = 5'd8;
      end
      OP_LD_E_I8: begin
        nxt.de[7:0] = lo; len = 2'd2; res.cycle_cost = 5'd8;
      end
      OP_LD_H_I8: begin
        nxt.hl[15:8] = lo; len = 2'd2; res.cycle_cost = 5'd8;
      end
      OP_LD_L_I8: begin
        nxt.hl[7:0] = lo; len = 2'd2; res.cycle_cost = 5'd8;
      end
      OP_ST_HL_I8: begin
        res.wr_count = WR_ONE; res.wr_addr = cur_i.hl;
        res.wr_data = {8'h00, lo}; len = 2'd2; res.cycle_cost = 5'd12;
      end
      OP_LD_A_I8: begin
        nxt.a = lo; len = 2'd2; res.cycle_cost = 5'd8;
      end
      OP_DEC_C: begin
        // half carry is a borrow out of the low nibble
        nxt.bc[7:0]        = dec_c;
        nxt.flags[FLAG_Z]  = (dec_c == 8'h00);
        nxt.flags[FLAG_N]  = 1'b1;
        nxt.flags[FLAG_H]  = (cur_i.bc[3:0] == 4'h0);
        res.cycle_cost     = 5'd4;
      end
      OP_CPL: begin
        nxt.a             = ~cur_i.a;
        nxt.flags[FLAG_N] = 1'b1;
        nxt.flags[FLAG_H] = 1'b1;
        res.cycle_cost    = 5'd4;
      end
      OP_XOR_B: begin
        nxt.a = cur_i.a ^ cur_i.bc[15:8];
        nxt.flags = 4'b0000;
        nxt.flags[FLAG_Z] = ((cur_i.a ^ cur_i.bc[15:8]) == 8'h00);
        res.cycle_cost = 5'd4;
      end
      OP_XOR_A: begin
        nxt.a = 8'h00;
        nxt.flags = 4'b0000;
        nxt.flags[FLAG_Z] = 1'b1;
        res.cycle_cost = 5'd4;
      end
      OP_JP_A16: begin
        jump = 1'b1; res.cycle_cost = 5'd16;
      end
      OP_ADD_A_I8: begin
        nxt.a = add_sum[7:0];
        nxt.flags = 4'b0000;
        nxt.flags[FLAG_Z] = (add_sum[7:0] == 8'h00);
        nxt.flags[FLAG_H] = add_half[4];
        nxt.flags[FLAG_C] = add_sum[8];
        len = 2'd2; res.cycle_cost = 5'd8;
      end
      OP_CALL_A16: begin
        // push return address, high byte at sp-1
        res.wr_count = WR_TWO;
        res.wr_addr  = cur_i.sp - 16'd1;
        res.wr_data  = cur_i.pc + 16'd3;
        nxt.sp       = cur_i.sp - 16'd2;
        jump = 1'b1; res.cycle_cost = 5'd24;
      end
      OP_LDH_ST_A: begin
        res.wr_count = WR_ONE; res.wr_addr = {HIGH_PAGE, lo};
        res.wr_data = {8'h00, cur_i.a}; len = 2'd2; res.cycle_cost = 5'd12;
      end
      OP_LDH_LD_A: begin
        nxt.a = insn_i.mem_rdata; len = 2'd2; res.cycle_cost = 5'd12;
      end
      OP_LD_HL_SPR: begin
        nxt.hl = sp_sum;
        nxt.flags = 4'b0000;
        nxt.flags[FLAG_H] = sp_half[4];
        nxt.flags[FLAG_C] = sp_lo_sum[8];
        len = 2'd2; res.cycle_cost = 5'd12;
      end
      OP_LD_SP_HL: begin
        nxt.sp = cur_i.hl; res.cycle_cost = 5'd8;
      end
      default: begin
        res.unimplemented = 1'b1;
      end
    endcase

    // next fetch address
    if (res.unimplemented) begin
      nxt.pc = cur_i.pc;
    end else if (jump) begin
      nxt.pc = imm16;
    end else begin
      nxt.pc = cur_i.pc + {14'd0, len};
    end
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule

// ===== src/sm83_subset_instruction_executor.sv =====
// path: an accepted instruction beat goes through the input register,
// then executes into the result register
// throughput: one instruction per cycle unless the result side stalls;
// the register file updates in the same cycle the result register loads,
// so back-to-back instructions chain
// reset: asynchronous active low; RESET_STATE loads, both valids clear
`include "sm83_subset_instruction_executor_assert.svh"

module sm83_subset_instruction_executor (
  input logic        clk_i,
  input logic        rst_ni,
  sm83_in_if.sink    in_i,
  sm83_out_if.source out_o
);
  import sm83_pkg::*;

  insn_t       in_insn;
  insn_t       s1_insn;
  logic        s1_valid;
  logic        adv;
  arch_state_t state_q, state_d;
  arch_state_t exec_nxt;
  exec_res_t   exec_res;
  logic        out_valid_q, out_valid_d;
  arch_state_t out_state_q;
  exec_res_t   out_res_q;

  assign in_insn = '{opcode: in_i.opcode, imm_lo: in_i.imm_lo,
                     imm_hi: in_i.imm_hi, mem_rdata: in_i.mem_rdata};

  // the held instruction executes when the result register is free or being read out
  assign adv = s1_valid && (!out_valid_q || out_o.ready);

  // input register
  sm83_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_insn_i  (in_insn),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .insn_o     (s1_insn)
  );

  // execute
  sm83_exec u_exec (
    .cur_i  (state_q),
    .insn_i (s1_insn),
    .nxt_o  (exec_nxt),
    .res_o  (exec_res)
  );

  // architectural registers
  always_comb begin
    state_d = state_q;
    if (adv) begin
      state_d = exec_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RESET_STATE;
    end else begin
      state_q <= state_d;
    end
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_state_q <= exec_nxt;
      out_res_q   <= exec_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.next_pc       = out_state_q.pc;
  assign out_o.acc           = out_state_q.a;
  assign out_o.pair_bc       = out_state_q.bc;
  assign out_o.pair_de       = out_state_q.de;
  assign out_o.pair_hl       = out_state_q.hl;
  assign out_o.stack_ptr     = out_state_q.sp;
  assign out_o.flag_bits     = out_state_q.flags;
  assign out_o.wr_count      = out_res_q.wr_count;
  assign out_o.wr_addr       = out_res_q.wr_addr;
  assign out_o.wr_data       = out_res_q.wr_data;
  assign out_o.cycle_cost    = out_res_q.cycle_cost;
  assign out_o.unimplemented = out_res_q.unimplemented;

  // checks
  `SM83_ASSERT(a_exec_pc_match, clk_i, rst_ni, adv |=> (state_q == out_state_q))
  `SM83_ASSERT(a_unimpl_keeps_state, clk_i, rst_ni, (adv && exec_res.unimplemented) |=> $stable(state_q))
  `SM83_ASSERT(a_unimpl_no_effect, clk_i, rst_ni, (out_valid_q && out_res_q.unimplemented) |-> (out_res_q.cycle_cost == 5'd0 && out_res_q.wr_count == WR_NONE))
  `SM83_ASSERT(a_state_only_on_exec, clk_i, rst_ni, !adv |=> $stable(state_q))
  `SM83_ASSERT_NEVER(a_wr_count_range, clk_i, rst_ni, adv && exec_res.wr_count == 2'd3)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sm83_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 5;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLD_LEN       = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_DIRECTED   = 40;

  // opcodes outside the subset, used on purpose
  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_JR_NZ     = 8'h20;
  localparam logic [7:0] OP_LD_A16_SP = 8'h08;
  localparam logic [7:0] OP_RST_38    = 8'hff;

  localparam logic [7:0] SUPPORTED_OPS [31] = '{
    OP_LD_BC_I16, OP_LD_DE_I16, OP_LD_HL_I16, OP_LD_SP_I16, OP_ST_BC_A,
    OP_ST_DE_A, OP_LD_A_BC, OP_LD_A_DE, OP_ST_HLI_A, OP_LD_A_HLI,
    OP_ST_HLD_A, OP_LD_A_HLD, OP_LD_B_I8, OP_LD_C_I8, OP_LD_D_I8,
    OP_LD_E_I8, OP_LD_H_I8, OP_LD_L_I8, OP_ST_HL_I8, OP_LD_A_I8,
    OP_DEC_C, OP_CPL, OP_XOR_B, OP_XOR_A, OP_JP_A16, OP_ADD_A_I8,
    OP_CALL_A16, OP_LDH_ST_A, OP_LDH_LD_A, OP_LD_HL_SPR, OP_LD_SP_HL
  };

  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  acc;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [3:0]  flags;
    logic [1:0]  wr_count;
    logic [15:0] wr_addr;
    logic [15:0] wr_data;
    logic [4:0]  cost;
    logic        unimpl;
  } retire_t;

  // unlisted opcode straight after reset: nothing moves
  localparam retire_t UNIMPL_AT_RESET = '{
    next_pc: 16'h0000, acc: 8'h11, bc: 16'h0000, de: 16'hff56, hl: 16'h000d,
    sp: 16'hfffe, flags: 4'b1000, wr_count: WR_NONE, wr_addr: 16'h0000,
    wr_data: 16'h0000, cost: 5'd0, unimpl: 1'b1
  };

  typedef struct packed {
    insn_t ins;
    logic  typed;
  } dir_row_t;

  // opcode, imm_lo, imm_hi, mem_rdata; typed rows carry UNIMPL_AT_RESET
  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{{OP_NOP,       8'h00, 8'h00, 8'h00}, 1'b1},
    '{{OP_JR_NZ,     8'hff, 8'hff, 8'hff}, 1'b1},
    '{{OP_LD_A16_SP, 8'hff, 8'hff, 8'hff}, 1'b1},
    '{{OP_RST_38,    8'h00, 8'h00, 8'hff}, 1'b1},
    '{{OP_LD_BC_I16, 8'hff, 8'hff, 8'h00}, 1'b0},
    '{{OP_DEC_C,     8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_C_I8,   8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_DEC_C,     8'hff, 8'hff, 8'hff}, 1'b0},
    '{{OP_LD_C_I8,   8'h01, 8'h00, 8'h00}, 1'b0},
    '{{OP_DEC_C,     8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_B_I8,   8'ha5, 8'h00, 8'h00}, 1'b0},
    '{{OP_XOR_B,     8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_XOR_A,     8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_CPL,       8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_ADD_A_I8,  8'h01, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_HL_I16, 8'hff, 8'hff, 8'h00}, 1'b0},
    '{{OP_ST_HLI_A,  8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_ST_HLD_A,  8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_A_HLI,  8'h00, 8'h00, 8'hff}, 1'b0},
    '{{OP_LD_A_HLD,  8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_A_I8,   8'h80, 8'h00, 8'h00}, 1'b0},
    '{{OP_ST_BC_A,   8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_DE_I16, 8'h34, 8'h12, 8'h00}, 1'b0},
    '{{OP_ST_DE_A,   8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_A_BC,   8'h00, 8'h00, 8'h5a}, 1'b0},
    '{{OP_LD_A_DE,   8'h00, 8'h00, 8'ha5}, 1'b0},
    '{{OP_LD_D_I8,   8'hff, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_E_I8,   8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_H_I8,   8'h80, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_L_I8,   8'h7f, 8'h00, 8'h00}, 1'b0},
    '{{OP_ST_HL_I8,  8'hff, 8'h00, 8'h00}, 1'b0},
    '{{OP_LDH_ST_A,  8'hff, 8'h00, 8'h00}, 1'b0},
    '{{OP_LDH_LD_A,  8'h00, 8'h00, 8'h3c}, 1'b0},
    '{{OP_LD_SP_I16, 8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_CALL_A16,  8'hfe, 8'hff, 8'h00}, 1'b0},
    '{{OP_LD_HL_SPR, 8'h80, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_HL_SPR, 8'h7f, 8'h00, 8'h00}, 1'b0},
    '{{OP_LD_SP_HL,  8'h00, 8'h00, 8'h00}, 1'b0},
    '{{OP_JP_A16,    8'hff, 8'hff, 8'h00}, 1'b0},
    '{{OP_LD_BC_I16, 8'h00, 8'h00, 8'h00}, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  sm83_in_if  instr_if ();
  sm83_out_if result_if ();

  sm83_subset_instruction_executor u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (instr_if),
    .out_o  (result_if)
  );

  arch_state_t cpu_state;
  retire_t     retire_q[$];
  int          mismatches    = 0;
  int          idle_pct      = 0;
  int          stall_pct     = 0;
  bit          long_hold_req = 1'b0;
  int          hold_cnt      = 0;
  int          quiet_cycles  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // executes one instruction on the shadow registers, returns what retires
  function automatic retire_t execute_insn(insn_t ins);
    retire_t     r;
    logic [15:0] imm16;
    logic [15:0] len;
    logic [15:0] ext;
    logic [15:0] new_pc;
    logic [7:0]  c_new;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [3:0]  f;
    logic        jumped;
    imm16  = {ins.imm_hi, ins.imm_lo};
    r      = '0;
    len    = 16'd1;
    jumped = 1'b0;
    new_pc = '0;
    f      = '0;
    case (ins.opcode)
      OP_LD_BC_I16: begin cpu_state.bc = imm16; len = 16'd3; r.cost = 5'd12; end
      OP_LD_DE_I16: begin cpu_state.de = imm16; len = 16'd3; r.cost = 5'd12; end
      OP_LD_HL_I16: begin cpu_state.hl = imm16; len = 16'd3; r.cost = 5'd12; end
      OP_LD_SP_I16: begin cpu_state.sp = imm16; len = 16'd3; r.cost = 5'd12; end
      OP_ST_BC_A, OP_ST_DE_A: begin
        r.wr_count = WR_ONE;
        r.wr_addr  = (ins.opcode == OP_ST_BC_A) ? cpu_state.bc : cpu_state.de;
        r.wr_data  = {8'h00, cpu_state.a};
        r.cost     = 5'd8;
      end
      OP_LD_A_BC, OP_LD_A_DE: begin
        cpu_state.a = ins.mem_rdata;
        r.cost      = 5'd8;
      end
      // store through hl, then step hl up or down
      OP_ST_HLI_A, OP_ST_HLD_A: begin
        r.wr_count   = WR_ONE;
        r.wr_addr    = cpu_state.hl;
        r.wr_data    = {8'h00, cpu_state.a};
        cpu_state.hl = (ins.opcode == OP_ST_HLI_A) ? cpu_state.hl + 16'd1
                                                   : cpu_state.hl - 16'd1;
        r.cost       = 5'd8;
      end
      OP_LD_A_HLI, OP_LD_A_HLD: begin
        cpu_state.a  = ins.mem_rdata;
        cpu_state.hl = (ins.opcode == OP_LD_A_HLI) ? cpu_state.hl + 16'd1
                                                   : cpu_state.hl - 16'd1;
        r.cost       = 5'd8;
      end
      OP_LD_B_I8: begin cpu_state.bc[15:8] = ins.imm_lo; len = 16'd2; r.cost = 5'd8; end
      OP_LD_C_I8: begin cpu_state.bc[7:0]  = ins.imm_lo; len = 16'd2; r.cost = 5'd8; end
      OP_LD_D_I8: begin cpu_state.de[15:8] = ins.imm_lo; len = 16'd2; r.cost = 5'd8; end
      OP_LD_E_I8: begin cpu_state.de[7:0]  = ins.imm_lo; len = 16'd2; r.cost = 5'd8; end
      OP_LD_H_I8: begin cpu_state.hl[15:8] = ins.imm_lo; len = 16'd2; r.cost = 5'd8; end
      OP_LD_L_I8: begin cpu_state.hl[7:0]  = ins.imm_lo; len = 16'd2; r.cost = 5'd8; end
      OP_LD_A_I8: begin cpu_state.a        = ins.imm_lo; len = 16'd2; r.cost = 5'd8; end
      OP_ST_HL_I8: begin
        r.wr_count = WR_ONE;
        r.wr_addr  = cpu_state.hl;
        r.wr_data  = {8'h00, ins.imm_lo};
        len        = 16'd2;
        r.cost     = 5'd12;
      end
      // carry kept, half carry on a borrow out of the low nibble
      OP_DEC_C: begin
        c_new              = cpu_state.bc[7:0] - 8'd1;
        f[FLAG_C]          = cpu_state.flags[FLAG_C];
        f[FLAG_N]          = 1'b1;
        f[FLAG_H]          = (cpu_state.bc[3:0] == 4'h0);
        f[FLAG_Z]          = (c_new == 8'h00);
        cpu_state.flags    = f;
        cpu_state.bc[7:0]  = c_new;
        r.cost             = 5'd4;
      end
      OP_CPL: begin
        cpu_state.a            = ~cpu_state.a;
        cpu_state.flags[FLAG_N] = 1'b1;
        cpu_state.flags[FLAG_H] = 1'b1;
        r.cost                 = 5'd4;
      end
      OP_XOR_B, OP_XOR_A: begin
        cpu_state.a     = (ins.opcode == OP_XOR_A) ? 8'h00
                                                   : cpu_state.a ^ cpu_state.bc[15:8];
        f[FLAG_Z]       = (cpu_state.a == 8'h00);
        cpu_state.flags = f;
        r.cost          = 5'd4;
      end
      OP_JP_A16: begin new_pc = imm16; jumped = 1'b1; r.cost = 5'd16; end
      OP_ADD_A_I8: begin
        sum9            = {1'b0, cpu_state.a} + {1'b0, ins.imm_lo};
        nib5            = {1'b0, cpu_state.a[3:0]} + {1'b0, ins.imm_lo[3:0]};
        cpu_state.a     = sum9[7:0];
        f[FLAG_Z]       = (sum9[7:0] == 8'h00);
        f[FLAG_H]       = nib5[4];
        f[FLAG_C]       = sum9[8];
        cpu_state.flags = f;
        len             = 16'd2;
        r.cost          = 5'd8;
      end
      // return address pushed high byte first
      OP_CALL_A16: begin
        r.wr_count   = WR_TWO;
        r.wr_addr    = cpu_state.sp - 16'd1;
        r.wr_data    = cpu_state.pc + 16'd3;
        cpu_state.sp = cpu_state.sp - 16'd2;
        new_pc       = imm16;
        jumped       = 1'b1;
        r.cost       = 5'd24;
      end
      OP_LDH_ST_A: begin
        r.wr_count = WR_ONE;
        r.wr_addr  = {HIGH_PAGE, ins.imm_lo};
        r.wr_data  = {8'h00, cpu_state.a};
        len        = 16'd2;
        r.cost     = 5'd12;
      end
      OP_LDH_LD_A: begin cpu_state.a = ins.mem_rdata; len = 16'd2; r.cost = 5'd12; end
      // flags from the unsigned add of the offset byte to sp's low byte
      OP_LD_HL_SPR: begin
        ext             = {{8{ins.imm_lo[7]}}, ins.imm_lo};
        nib5            = {1'b0, cpu_state.sp[3:0]} + {1'b0, ins.imm_lo[3:0]};
        sum9            = {1'b0, cpu_state.sp[7:0]} + {1'b0, ins.imm_lo};
        f[FLAG_H]       = nib5[4];
        f[FLAG_C]       = sum9[8];
        cpu_state.hl    = cpu_state.sp + ext;
        cpu_state.flags = f;
        len             = 16'd2;
        r.cost          = 5'd12;
      end
      OP_LD_SP_HL: begin cpu_state.sp = cpu_state.hl; r.cost = 5'd8; end
      default: begin
        r.unimpl = 1'b1;
        len      = 16'd0;
      end
    endcase
    if (!jumped) new_pc = cpu_state.pc + len;
    cpu_state.pc = new_pc;
    r.next_pc    = cpu_state.pc;
    r.acc        = cpu_state.a;
    r.bc         = cpu_state.bc;
    r.de         = cpu_state.de;
    r.hl         = cpu_state.hl;
    r.sp         = cpu_state.sp;
    r.flags      = cpu_state.flags;
    return r;
  endfunction

  // immediates lean toward the byte extremes
  function automatic logic [7:0] pick_imm();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h7f;
      3: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit field_ok(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // offers one instruction beat, records its retirement once accepted
  task automatic issue_insn(input insn_t ins, input bit typed, input retire_t want);
    retire_t pred;
    while ($urandom_range(0, 99) < idle_pct) begin
      instr_if.valid <= 1'b0;
      @(posedge clk);
    end
    instr_if.valid     <= 1'b1;
    instr_if.opcode    <= ins.opcode;
    instr_if.imm_lo    <= ins.imm_lo;
    instr_if.imm_hi    <= ins.imm_hi;
    instr_if.mem_rdata <= ins.mem_rdata;
    @(posedge clk);
    while (!instr_if.ready) @(posedge clk);
    pred = execute_insn(ins);
    retire_q.push_back(typed ? want : pred);
  endtask

  // result side backpressure, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else if (long_hold_req && hold_cnt < HOLD_LEN) begin
      result_if.ready <= 1'b0;
      hold_cnt        <= hold_cnt + 1;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // compare every retired beat with the oldest expectation
  always @(posedge clk) begin : result_check
    retire_t want;
    bit      ok;
    if (rst_n && result_if.valid && result_if.ready) begin
      if (retire_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, next_pc 0x%0h", $time,
                 result_if.next_pc);
        mismatches++;
      end else begin
        want = retire_q.pop_front();
        ok   = 1'b1;
        ok &= field_ok("next_pc", want.next_pc, result_if.next_pc);
        ok &= field_ok("acc", 16'(want.acc), 16'(result_if.acc));
        ok &= field_ok("pair_bc", want.bc, result_if.pair_bc);
        ok &= field_ok("pair_de", want.de, result_if.pair_de);
        ok &= field_ok("pair_hl", want.hl, result_if.pair_hl);
        ok &= field_ok("stack_ptr", want.sp, result_if.stack_ptr);
        ok &= field_ok("flag_bits", 16'(want.flags), 16'(result_if.flag_bits));
        ok &= field_ok("wr_count", 16'(want.wr_count), 16'(result_if.wr_count));
        ok &= field_ok("wr_addr", want.wr_addr, result_if.wr_addr);
        ok &= field_ok("wr_data", want.wr_data, result_if.wr_data);
        ok &= field_ok("cycle_cost", 16'(want.cost), 16'(result_if.cycle_cost));
        ok &= field_ok("unimplemented", 16'(want.unimpl), 16'(result_if.unimplemented));
        if (!ok) mismatches++;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((instr_if.valid && instr_if.ready) || (result_if.valid && result_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** sm83_subset_instruction_executor: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    insn_t ins;
    int    ph;
    rst_n              = 1'b0;
    instr_if.valid     = 1'b0;
    instr_if.opcode    = '0;
    instr_if.imm_lo    = '0;
    instr_if.imm_hi    = '0;
    instr_if.mem_rdata = '0;
    result_if.ready    = 1'b0;
    cpu_state          = RESET_STATE;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      issue_insn(DIRECTED_ROWS[i].ins, DIRECTED_ROWS[i].typed, UNIMPL_AT_RESET);
    end

    // random phases with different idle and stall patterns
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  long_hold_req <= 1'b1; end
        1: begin idle_pct = 59; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 59; end
        default: begin idle_pct = 11; stall_pct <= 11; end
      endcase
      repeat (PHASE_ITEMS) begin
        // mostly subset opcodes, some raw opcode bytes
        if ($urandom_range(0, 99) < 85) begin
          ins.opcode = SUPPORTED_OPS[$urandom_range(0, 30)];
        end else begin
          ins.opcode = 8'($urandom_range(0, 255));
        end
        ins.imm_lo    = pick_imm();
        ins.imm_hi    = pick_imm();
        ins.mem_rdata = 8'($urandom_range(0, 255));
        issue_insn(ins, 1'b0, UNIMPL_AT_RESET);
      end
      // sender pauses until every result is back
      instr_if.valid <= 1'b0;
      do @(posedge clk); while (retire_q.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && retire_q.size() == 0) begin
      $display("** sm83_subset_instruction_executor: PASSED **");
    end else begin
      $display("** sm83_subset_instruction_executor: FAILED **");
    end
    $finish;
  end

endmodule
